// File: design/bps_pkg.sv
package bps_pkg;

  // Selector codes carried in the input tuser.
  localparam logic [1:0] FUNC_NEW_FLOW = 2'd0;
  localparam logic [1:0] FUNC_PACKET   = 2'd1;
  localparam logic [1:0] FUNC_EXPORT   = 2'd2;

  // Configuration register indexes (paddr[2]).
  localparam logic REG_MAX_GAP   = 1'b0;
  localparam logic REG_MIN_BURST = 1'b1;

  localparam int          APB_ADDR_W      = 3;
  localparam logic [31:0] MAX_GAP_RESET   = 32'd1000000;
  localparam logic [15:0] MIN_BURST_RESET = 16'd3;

  typedef enum logic [1:0] {
    CMD_NEW_FLOW,
    CMD_PACKET,
    CMD_EXPORT
  } cmd_kind_e;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_e   kind;
    logic        dir;
    logic [15:0] len;
    logic [47:0] t;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic        kept;
    logic        has_burst;
    logic        dir;
    logic [3:0]  index;
    logic [31:0] pkts;
    logic [31:0] bytes;
    logic [47:0] first_us;
    logic [47:0] last_us;
    logic        last;
  } res_t;

endpackage

// File: design/bps_front.sv
module bps_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_vld_i,
  output logic          in_rdy_o,
  input  logic [1:0]    func_i,
  input  logic          dir_i,
  input  logic [15:0]   len_i,
  input  logic [47:0]   t_i,
  output logic          cmd_vld_o,
  input  logic          cmd_rdy_i,
  output bps_pkg::cmd_t cmd_o
);

  logic          vld_q, vld_d;
  bps_pkg::cmd_t cmd_q, cmd_d;
  logic          accept;
  logic          keep;
  bps_pkg::cmd_kind_e kind;

  // The stage takes a new word whenever it is empty or being drained.
  assign in_rdy_o = !vld_q || cmd_rdy_i;
  assign accept   = in_vld_i && in_rdy_o;

  // Decode the selector; unused selectors are accepted and dropped here.
  always_comb begin
    keep = 1'b1;
    kind = bps_pkg::CMD_PACKET;
    case (func_i)
      bps_pkg::FUNC_NEW_FLOW: kind = bps_pkg::CMD_NEW_FLOW;
      bps_pkg::FUNC_PACKET:   kind = bps_pkg::CMD_PACKET;
      bps_pkg::FUNC_EXPORT:   kind = bps_pkg::CMD_EXPORT;
      default:                keep = 1'b0;
    endcase
  end

  always_comb begin
    vld_d = vld_q && !cmd_rdy_i;
    cmd_d = cmd_q;
    if (accept) begin
      vld_d = keep;
      cmd_d = '{kind: kind, dir: dir_i, len: len_i, t: t_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_vld_o = vld_q;
  assign cmd_o     = cmd_q;

endmodule

// File: design/bps_cmd_fifo.sv
module bps_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_vld_i,
  output logic          push_rdy_o,
  input  bps_pkg::cmd_t push_i,
  output logic          pop_vld_o,
  input  logic          pop_i,
  output bps_pkg::cmd_t pop_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  bps_pkg::cmd_t      buf_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    cnt_q;
  logic               push, pop;

  assign push_rdy_o = cnt_q != CntW'(Depth);
  assign pop_vld_o  = cnt_q != '0;
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_i && pop_vld_o;
  assign pop_o      = buf_q[rd_ptr_q];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

// File: design/bps_back.sv
module bps_back #(
  parameter int MAX_BURSTS = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_vld_i,
  input  bps_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic [31:0]   max_gap_i,
  input  logic [15:0]   min_burst_i,
  output logic          res_vld_o,
  input  logic          res_ready_i,
  output bps_pkg::res_t res_o
);

  localparam int IdxW  = (MAX_BURSTS > 1) ? $clog2(MAX_BURSTS) : 1;
  localparam int AddrW = IdxW + 1;
  localparam int Depth = 2 ** AddrW;
  localparam int CntW  = $clog2(MAX_BURSTS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BURSTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PKT  = 3'd1;
  localparam logic [2:0] ST_XDEC = 3'd2;
  localparam logic [2:0] ST_XC0  = 3'd3;
  localparam logic [2:0] ST_XC1  = 3'd4;
  localparam logic [2:0] ST_WALK = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  typedef struct packed {
    logic [31:0] pkts;
    logic [31:0] bytes;
    logic [47:0] first_us;
    logic [47:0] last_us;
  } slot_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Burst record memory, addressed by {direction, slot}.
  slot_t                  mem [Depth];
  slot_t                  rd_q;
  logic                   rd_vld_q;
  logic [AddrW-1:0]       rd_addr;
  logic                   wr_en;
  logic [AddrW-1:0]       wr_addr;
  slot_t                  wr_data;
  logic [Depth-1:0]       slot_vld_q, slot_vld_d;
  logic                   vld_clr;

  logic [2:0]             state_q, state_d;
  logic [1:0]             started_q, started_d;
  logic [1:0][CntW-1:0]   closed_q, closed_d;
  logic [31:0]            fp_q, fp_d;
  bps_pkg::cmd_t          cur_q, cur_d;
  logic                   wd_q, wd_d;
  logic [CntW-1:0]        wi_q, wi_d;
  logic                   emit_dir_q, emit_dir_d;
  logic [CntW-1:0]        emit_idx_q, emit_idx_d;
  logic                   out_vld_q, out_vld_d;
  bps_pkg::res_t          out_q, out_d;

  logic                   out_free;
  logic [31:0]            eff_pkts;
  logic                   enough;
  logic [CntW-1:0]        cur_i, pk_ni;
  logic [47:0]            pk_gap;
  logic                   pk_join;
  logic                   in_clr, in_started;
  logic [CntW-1:0]        in_i;

  assign out_free   = !out_vld_q || res_ready_i;
  assign eff_pkts   = rd_vld_q ? rd_q.pkts : 32'd0;
  assign enough     = eff_pkts >= {16'd0, min_burst_i};
  assign cur_i      = closed_q[cur_q.dir];
  assign pk_ni      = enough ? cur_i + CntW'(1) : cur_i;
  assign pk_gap     = cur_q.t - rd_q.last_us;
  assign pk_join    = (cur_q.t < rd_q.last_us) || (pk_gap < {16'd0, max_gap_i});
  assign in_clr     = cmd_i.kind == bps_pkg::CMD_NEW_FLOW;
  assign in_i       = in_clr ? '0 : closed_q[cmd_i.dir];
  assign in_started = !in_clr && started_q[cmd_i.dir];

  // Sequencer: packet read-modify-write, export close pass and list walk.
  always_comb begin
    state_d    = state_q;
    started_d  = started_q;
    closed_d   = closed_q;
    fp_d       = fp_q;
    cur_d      = cur_q;
    wd_d       = wd_q;
    wi_d       = wi_q;
    emit_dir_d = emit_dir_q;
    emit_idx_d = emit_idx_q;
    out_vld_d  = out_vld_q && !res_ready_i;
    out_d      = out_q;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    rd_addr    = '0;
    vld_clr    = 1'b0;
    cmd_pop_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          if (cmd_i.kind == bps_pkg::CMD_EXPORT) begin
            state_d = ST_XDEC;
          end else begin
            if (in_clr) begin
              started_d = '0;
              closed_d  = '0;
              vld_clr   = 1'b1;
              fp_d      = 32'd1;
            end else begin
              fp_d = sat_add32(fp_q, 32'd1);
            end
            if (cmd_i.len != 16'd0 && in_i < MaxCnt) begin
              if (!in_started) begin
                // First packet of the direction opens its record directly.
                started_d[cmd_i.dir] = 1'b1;
                wr_en   = 1'b1;
                wr_addr = {cmd_i.dir, in_i[IdxW-1:0]};
                wr_data = '{pkts: 32'd1, bytes: 32'(cmd_i.len),
                            first_us: cmd_i.t, last_us: cmd_i.t};
              end else begin
                rd_addr = {cmd_i.dir, in_i[IdxW-1:0]};
                state_d = ST_PKT;
              end
            end
          end
        end
      end
      ST_PKT: begin
        state_d = ST_IDLE;
        if (pk_join) begin
          wr_en   = 1'b1;
          wr_addr = {cur_q.dir, cur_i[IdxW-1:0]};
          wr_data = '{pkts: sat_add32(eff_pkts, 32'd1),
                      bytes: sat_add32(rd_q.bytes, 32'(cur_q.len)),
                      first_us: rd_q.first_us, last_us: cur_q.t};
        end else begin
          // Gap too long: close the record if it qualifies, then reopen while slots remain.
          closed_d[cur_q.dir] = pk_ni;
          if (pk_ni < MaxCnt) begin
            wr_en   = 1'b1;
            wr_addr = {cur_q.dir, pk_ni[IdxW-1:0]};
            wr_data = '{pkts: 32'd1, bytes: 32'(cur_q.len),
                        first_us: cur_q.t, last_us: cur_q.t};
          end
        end
      end
      ST_XDEC: begin
        if (fp_q <= {16'd0, min_burst_i}) begin
          // Dropped flow: a single empty final word.
          if (out_free) begin
            out_vld_d = 1'b1;
            out_d     = '0;
            out_d.last = 1'b1;
            state_d   = ST_IDLE;
          end
        end else begin
          rd_addr = {1'b0, closed_q[0][IdxW-1:0]};
          state_d = ST_XC0;
        end
      end
      ST_XC0: begin
        if (started_q[0] && closed_q[0] < MaxCnt && enough) begin
          closed_d[0] = closed_q[0] + CntW'(1);
        end
        rd_addr = {1'b1, closed_q[1][IdxW-1:0]};
        state_d = ST_XC1;
      end
      ST_XC1: begin
        if (started_q[1] && closed_q[1] < MaxCnt && enough) begin
          closed_d[1] = closed_q[1] + CntW'(1);
        end
        wd_d    = 1'b0;
        wi_d    = '0;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (!wd_q && wi_q == closed_q[0]) begin
          wd_d = 1'b1;
          wi_d = '0;
        end else if (wd_q && wi_q == closed_q[1]) begin
          if (closed_q[0] == '0 && closed_q[1] == '0) begin
            // Kept flow without any burst.
            if (out_free) begin
              out_vld_d  = 1'b1;
              out_d      = '0;
              out_d.kept = 1'b1;
              out_d.last = 1'b1;
              state_d    = ST_IDLE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end else if (out_free) begin
          rd_addr    = {wd_q, wi_q[IdxW-1:0]};
          emit_dir_d = wd_q;
          emit_idx_d = wi_q;
          wi_d       = wi_q + CntW'(1);
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_vld_d       = 1'b1;
        out_d.kept      = 1'b1;
        out_d.has_burst = 1'b1;
        out_d.dir       = emit_dir_q;
        out_d.index     = 4'(emit_idx_q);
        out_d.pkts      = eff_pkts;
        out_d.bytes     = rd_q.bytes;
        out_d.first_us  = rd_q.first_us;
        out_d.last_us   = rd_q.last_us;
        out_d.last      = emit_dir_q ? (emit_idx_q + CntW'(1) == closed_q[1])
                                     : (emit_idx_q + CntW'(1) == closed_q[0] &&
                                        closed_q[1] == '0);
        state_d         = ST_WALK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Per-slot valid bits give the cleared packet count without a sweep.
  always_comb begin
    slot_vld_d = vld_clr ? '0 : slot_vld_q;
    if (wr_en) begin
      slot_vld_d[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      started_q  <= '0;
      closed_q   <= '0;
      fp_q       <= '0;
      slot_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      wd_q       <= 1'b0;
      wi_q       <= '0;
    end else begin
      state_q    <= state_d;
      started_q  <= started_d;
      closed_q   <= closed_d;
      fp_q       <= fp_d;
      slot_vld_q <= slot_vld_d;
      rd_vld_q   <= slot_vld_q[rd_addr];
      out_vld_q  <= out_vld_d;
      wd_q       <= wd_d;
      wi_q       <= wi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    emit_dir_q <= emit_dir_d;
    emit_idx_q <= emit_idx_d;
    out_q      <= out_d;
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign res_vld_o = out_vld_q;
  assign res_o     = out_q;

endmodule

// File: design/packet_burst_statistics.sv
// Packet: front register, then command queue; the back end opens a record or skips in its
// idle state, or reads the slot memory there and writes it back in ST_PKT. Export: taken
// in idle; ST_XDEC decides (a dropped flow answers there), ST_XC0 and ST_XC1 close open
// records, then the walk passes ST_WALK and ST_EMIT per burst word and ST_WALK at each
// list end; no new command is taken until the back end is idle. Reset (asynchronous, active
// low) empties the store and loads the register defaults; words are accepted right after reset.
module packet_burst_statistics #(
  parameter int MAX_BURSTS = 15
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [71:0]                    s_axis_tdata,  // from_destination, payload_length,
                                                        // arrival_us
  input  logic [1:0]                     s_axis_tuser,  // func
  // Result words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [167:0]                   m_axis_tdata,  // burst_direction, burst_index,
                                                        // burst_packets, burst_bytes,
                                                        // burst_start_us, burst_end_us
  output logic [1:0]                     m_axis_tuser,  // kept, has_burst
  output logic                           m_axis_tlast,
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [31:0]   max_gap_q;
  logic [15:0]   min_burst_q;
  logic          cfg_wr;

  logic          f_vld, f_rdy;
  bps_pkg::cmd_t f_cmd;
  logic          cmd_vld, cmd_pop;
  bps_pkg::cmd_t cmd;
  logic          res_vld;
  bps_pkg::res_t res;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q   <= bps_pkg::MAX_GAP_RESET;
      min_burst_q <= bps_pkg::MIN_BURST_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        bps_pkg::REG_MAX_GAP:   max_gap_q   <= pwdata;
        bps_pkg::REG_MIN_BURST: min_burst_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bps_pkg::REG_MAX_GAP:   prdata = max_gap_q;
      bps_pkg::REG_MIN_BURST: prdata = {16'd0, min_burst_q};
      default:                prdata = '0;
    endcase
  end

  bps_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s_axis_tvalid),
    .in_rdy_o  (s_axis_tready),
    .func_i    (s_axis_tuser),
    .dir_i     (s_axis_tdata[0]),
    .len_i     (s_axis_tdata[16:1]),
    .t_i       (s_axis_tdata[64:17]),
    .cmd_vld_o (f_vld),
    .cmd_rdy_i (f_rdy),
    .cmd_o     (f_cmd)
  );

  bps_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_vld_i (f_vld),
    .push_rdy_o (f_rdy),
    .push_i     (f_cmd),
    .pop_vld_o  (cmd_vld),
    .pop_i      (cmd_pop),
    .pop_o      (cmd)
  );

  bps_back #(
    .MAX_BURSTS (MAX_BURSTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_vld_i   (cmd_vld),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .max_gap_i   (max_gap_q),
    .min_burst_i (min_burst_q),
    .res_vld_o   (res_vld),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Result word packing.
  assign m_axis_tvalid = res_vld;
  assign m_axis_tdata  = {3'd0, res.last_us, res.first_us, res.bytes, res.pkts,
                          res.index, res.dir};
  assign m_axis_tuser  = {res.has_burst, res.kept};
  assign m_axis_tlast  = res.last;

  // A word without a burst always ends its export.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tlast)
    else $error("burst-less result word not marked last");

  // A dropped flow never carries a burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("dropped flow emitted a burst");

  // The back end only takes commands that the queue holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_vld)
    else $error("command popped from empty queue");

endmodule
